/* src/stb_pkg.sv */
package stb_pkg;

   localparam int SLOTS_DEFAULT = 8;
   localparam int DATA_W        = 32;
   localparam int FUNC_W        = 2;
   localparam int INDEX_W       = 8;
   localparam int KIND_W        = 3;
   localparam int SLOT_OUT_W    = 4;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_START   = 2'd0,
      FUNC_STOP    = 2'd1,
      FUNC_PROCESS = 2'd2
   } func_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ASSIGNED = 3'd0,
      KIND_NO_SLOT  = 3'd1,
      KIND_STOPPED  = 3'd2,
      KIND_EXPIRED  = 3'd3,
      KIND_DONE     = 3'd4
   } kind_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_PRIME = 5'b00100,
      ST_PROC  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

endpackage

/* src/stb_sat_cmp.sv */
module stb_sat_cmp (
   input  logic [stb_pkg::DATA_W-1:0] count,
   input  logic [stb_pkg::DATA_W-1:0] elapsed,
   input  logic [stb_pkg::DATA_W-1:0] period,
   output logic [stb_pkg::DATA_W-1:0] sum,
   output logic                       expired
);
   import stb_pkg::*;

   logic [DATA_W:0] raw_sum;

   assign raw_sum = {1'b0, count} + {1'b0, elapsed};
   assign sum     = raw_sum[DATA_W] ? {DATA_W{1'b1}} : raw_sum[DATA_W-1:0];
   assign expired = (sum >= period);

endmodule

/* src/software_timer_bank_unit.sv */
// Bank of SLOTS software timers driven by a command port.
// A request is taken on a rising edge with start high and busy low. The
// operation code selects start, stop or process; an unknown code is dropped.
// Start scans the slots from zero for the first free one, one slot a cycle,
// and answers with the slot number or a no-free-slot code. Stop answers
// in the cycle after the request and keeps busy low; an index at or above
// SLOTS gives no answer. Process first primes the period and count
// memories, then checks one slot a cycle through a single saturating adder
// and comparator, giving an expired answer for each running slot that
// reaches its period, and closes with a pass-done answer; busy stays high
// through the whole pass. Each answer is on the rsp_ ports for exactly one
// cycle, marked by rsp_strobe, and rsp_last is set on the final answer of
// a request. The receiver cannot stall, so answers are never held back.
// Reset marks every slot stopped; period and count memories are not cleared
// because their contents are only used for slots that a start has written.
module software_timer_bank_unit #(
   parameter int SLOTS = stb_pkg::SLOTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [stb_pkg::FUNC_W-1:0]     req_func,
   input  logic [stb_pkg::DATA_W-1:0]     req_duration,
   input  logic                           req_auto_reload,
   input  logic [stb_pkg::INDEX_W-1:0]    req_timer_index,
   input  logic [stb_pkg::DATA_W-1:0]     req_elapsed,
   output logic                           rsp_strobe,
   output logic [stb_pkg::KIND_W-1:0]     rsp_event_kind,
   output logic [stb_pkg::SLOT_OUT_W-1:0] rsp_slot,
   output logic                           rsp_last
);
   import stb_pkg::*;

   localparam int SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [SlotW-1:0]      LastIdx   = SlotW'(SLOTS - 1);
   localparam logic [INDEX_W-1:0]    SlotsIdx  = INDEX_W'(SLOTS);
   localparam logic [SLOT_OUT_W-1:0] SlotsCode = SLOT_OUT_W'(SLOTS);

   state_type              state_ff, state_in;
   logic [SlotW-1:0]       idx_ff, idx_in;
   logic [SLOTS-1:0]       running_ff, running_in;
   logic [SLOTS-1:0]       auto_ff, auto_in;

   logic [DATA_W-1:0]      duration_ff;
   logic                   auto_reload_ff;
   logic [DATA_W-1:0]      elapsed_ff;

   logic [DATA_W-1:0]      period_mem_ff [SLOTS];
   logic [DATA_W-1:0]      count_mem_ff  [SLOTS];
   logic [DATA_W-1:0]      period_rd_ff;
   logic [DATA_W-1:0]      count_rd_ff;
   logic [SlotW-1:0]       rd_addr;
   logic                   cnt_we;
   logic                   per_we;
   logic [DATA_W-1:0]      cnt_wdata;

   logic [DATA_W-1:0]      sat_sum;
   logic                   sat_expired;

   logic                   rsp_strobe_ff, rsp_strobe_in;
   kind_type               rsp_kind_ff, rsp_kind_in;
   logic [SLOT_OUT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   accept;
   logic [SlotW-1:0]       stop_idx;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign stop_idx = req_timer_index[SlotW-1:0];

   stb_sat_cmp u_sat_cmp (
      .count   (count_rd_ff),
      .elapsed (elapsed_ff),
      .period  (period_rd_ff),
      .sum     (sat_sum),
      .expired (sat_expired)
   );

   always_comb begin
      rd_addr = '0;
      if (state_ff == ST_PROC && idx_ff != LastIdx) begin
         rd_addr = idx_ff + SlotW'(1);
      end
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      running_in    = running_ff;
      auto_in       = auto_ff;
      rsp_strobe_in = 1'b0;
      rsp_kind_in   = KIND_DONE;
      rsp_slot_in   = '0;
      rsp_last_in   = 1'b0;
      cnt_we        = 1'b0;
      per_we        = 1'b0;
      cnt_wdata     = sat_sum;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in = '0;
               case (func_type'(req_func))
                  FUNC_START: begin
                     state_in = ST_SCAN;
                  end
                  FUNC_STOP: begin
                     if (req_timer_index < SlotsIdx) begin
                        running_in[stop_idx] = 1'b0;
                        auto_in[stop_idx]    = 1'b0;
                        rsp_strobe_in        = 1'b1;
                        rsp_kind_in          = KIND_STOPPED;
                        rsp_slot_in          = SLOT_OUT_W'(req_timer_index);
                        rsp_last_in          = 1'b1;
                     end
                  end
                  FUNC_PROCESS: begin
                     state_in = ST_PRIME;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (!running_ff[idx_ff]) begin
               running_in[idx_ff] = 1'b1;
               auto_in[idx_ff]    = auto_reload_ff;
               per_we             = 1'b1;
               cnt_we             = 1'b1;
               cnt_wdata          = '0;
               rsp_strobe_in      = 1'b1;
               rsp_kind_in        = KIND_ASSIGNED;
               rsp_slot_in        = SLOT_OUT_W'(idx_ff);
               rsp_last_in        = 1'b1;
               state_in           = ST_IDLE;
            end else if (idx_ff == LastIdx) begin
               rsp_strobe_in = 1'b1;
               rsp_kind_in   = KIND_NO_SLOT;
               rsp_slot_in   = SlotsCode;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               idx_in = idx_ff + SlotW'(1);
            end
         end
         ST_PRIME: begin
            state_in = ST_PROC;
         end
         ST_PROC: begin
            if (running_ff[idx_ff]) begin
               cnt_we = 1'b1;
               if (sat_expired) begin
                  rsp_strobe_in = 1'b1;
                  rsp_kind_in   = KIND_EXPIRED;
                  rsp_slot_in   = SLOT_OUT_W'(idx_ff);
                  if (auto_ff[idx_ff]) begin
                     cnt_wdata = '0;
                  end else begin
                     running_in[idx_ff] = 1'b0;
                  end
               end
            end
            if (idx_ff == LastIdx) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + SlotW'(1);
            end
         end
         ST_DONE: begin
            rsp_strobe_in = 1'b1;
            rsp_kind_in   = KIND_DONE;
            rsp_slot_in   = SlotsCode;
            rsp_last_in   = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         running_ff    <= '0;
         auto_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         running_ff    <= running_in;
         auto_ff       <= auto_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_last_ff <= rsp_last_in;
      if (accept) begin
         duration_ff    <= req_duration;
         auto_reload_ff <= req_auto_reload;
         elapsed_ff     <= req_elapsed;
      end
   end

   always_ff @(posedge clock) begin
      if (per_we) begin
         period_mem_ff[idx_ff] <= duration_ff;
      end
      if (cnt_we) begin
         count_mem_ff[idx_ff] <= cnt_wdata;
      end
      period_rd_ff <= period_mem_ff[rd_addr];
      count_rd_ff  <= count_mem_ff[rd_addr];
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_event_kind = rsp_kind_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_last       = rsp_last_ff;

   a_expired_from_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_kind_ff == KIND_EXPIRED |-> !rsp_last_ff && $past(state_ff == ST_PROC))
      else $error("expiry request outside a process pass or marked last");

   a_done_closes_pass: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> rsp_strobe_ff && rsp_kind_ff == KIND_DONE && rsp_last_ff)
      else $error("process pass did not close with a done request");

   a_assign_claims_one: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && !running_ff[idx_ff]
      |=> $countones(running_ff) == $past($countones(running_ff)) + 1)
      else $error("slot assignment did not claim exactly one free slot");

endmodule
